>>> design/blit_rect_clip_address_gen_macros.svh
// ----------------------------------------------------------------------------
// Blit rectangle clip address generator - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BLIT_RECT_CLIP_ADDRESS_GEN_MACROS_SVH
`define BLIT_RECT_CLIP_ADDRESS_GEN_MACROS_SVH

// Same-cycle implication
`define BRC_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BRC_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Widths, codes and shared types of the blit rectangle clip address generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

  localparam int DIM_W      = 13;  // buffer dimension
  localparam int COORD_W    = 16;  // signed command coordinate
  localparam int CLIP_W     = 19;  // clip arithmetic, coordinate plus dimension
  localparam int BPP_W      = 3;   // bytes per pixel
  localparam int OFS_W      = 26;  // byte offset
  localparam int ROWB_W     = 15;  // bytes per row
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_DIM_DEF = 4096;
  localparam int MAX_BPP_DEF = 4;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_WIDTH      = 3'd0,
    CFG_DEST_HEIGHT     = 3'd1,
    CFG_SOURCE_WIDTH    = 3'd2,
    CFG_SOURCE_HEIGHT   = 3'd3,
    CFG_BYTES_PER_PIXEL = 3'd4,
    CFG_FORMATS_MATCH   = 3'd5
  } cfg_idx_t;

  // Effective (saturated) configuration seen by the pipeline
  typedef struct packed {
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [BPP_W-1:0] bpp;
    logic             formats_match;
  } cfg_t;

  // Clipped span handed from the clip stages to the address stages.
  // All pixel fields are zero when status is not OK.
  typedef struct packed {
    status_t          status;
    logic             move;
    logic             up;
    logic [DIM_W-1:0] dcol;
    logic [DIM_W-1:0] scol;
    logic [DIM_W-1:0] drow;
    logic [DIM_W-1:0] srow;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } span_t;

endpackage

`default_nettype wire

>>> design/brc_cmd_if.sv
// ----------------------------------------------------------------------------
// brc_cmd_if
// Blit command channel: valid/ready plus the destination rectangle,
// source corner and opcode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [brc_pkg::COORD_W-1:0]  rect_left;
  logic signed [brc_pkg::COORD_W-1:0]  rect_top;
  logic signed [brc_pkg::COORD_W-1:0]  rect_right;
  logic signed [brc_pkg::COORD_W-1:0]  rect_bottom;
  logic signed [brc_pkg::COORD_W-1:0]  from_x;
  logic signed [brc_pkg::COORD_W-1:0]  from_y;

  modport source (
    output valid, opcode, rect_left, rect_top, rect_right, rect_bottom, from_x, from_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, rect_left, rect_top, rect_right, rect_bottom, from_x, from_y,
    output ready
  );
endinterface

`default_nettype wire

>>> design/brc_desc_if.sv
// ----------------------------------------------------------------------------
// brc_desc_if
// Row-transfer descriptor channel: valid/ready plus status, offsets,
// row count, bytes per row and walk direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brc_desc_if;
  logic                          valid;
  logic                          ready;
  brc_pkg::status_t              status;
  logic [brc_pkg::OFS_W-1:0]     dest_offset;
  logic [brc_pkg::OFS_W-1:0]     source_offset;
  logic [brc_pkg::DIM_W-1:0]     row_count;
  logic [brc_pkg::ROWB_W-1:0]    row_bytes;
  logic                          bottom_up;

  modport source (
    output valid, status, dest_offset, source_offset, row_count, row_bytes, bottom_up,
    input  ready
  );
  modport sink (
    input  valid, status, dest_offset, source_offset, row_count, row_bytes, bottom_up,
    output ready
  );
endinterface

`default_nettype wire

>>> design/brc_clip.sv
// ----------------------------------------------------------------------------
// brc_clip
// Two pipeline stages: clip bounds against both buffers and set the walk
// direction, then the empty test and first-row coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brc_clip (
  input  wire logic           clk,
  input  wire logic           rst_n,
  brc_cmd_if.sink             cmd,
  input  wire brc_pkg::cfg_t  cfg,
  output logic                span_valid,
  input  wire logic           span_ready,
  output brc_pkg::span_t      span
);

  localparam int CW = brc_pkg::CLIP_W;
  localparam int DW = brc_pkg::DIM_W;
  localparam int XW = brc_pkg::COORD_W;

  typedef struct packed {
    logic signed [CW-1:0] cl;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] ct;
    logic signed [CW-1:0] cb;
    logic signed [XW-1:0] left;
    logic signed [XW-1:0] top;
    logic signed [XW-1:0] fx;
    logic signed [XW-1:0] fy;
    logic                 move;
    logic                 up;
    logic                 mismatch;
  } clip_t;

  function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic                 a_valid_r, b_valid_r;
  logic                 a_ready, b_ready;
  clip_t                a_r, a_nxt;
  brc_pkg::span_t       b_r, b_nxt;

  logic signed [CW-1:0] left_x, top_x, right_x, bottom_x, fx_x, fy_x;
  logic signed [CW-1:0] dw_x, dh_x, sw_x, sh_x;
  logic signed [CW-1:0] row_base, dcol_x, scol_x, drow_x, srow_x, cols_x, rows_x;
  logic                 empty;

  // Stage A: clip window in rectangle-relative coordinates
  always_comb begin
    left_x   = CW'(cmd.rect_left);
    top_x    = CW'(cmd.rect_top);
    right_x  = CW'(cmd.rect_right);
    bottom_x = CW'(cmd.rect_bottom);
    fx_x     = CW'(cmd.from_x);
    fy_x     = CW'(cmd.from_y);
    dw_x     = $signed({{(CW-DW){1'b0}}, cfg.dw});
    dh_x     = $signed({{(CW-DW){1'b0}}, cfg.dh});
    // a move uses the destination as its source
    sw_x     = cmd.opcode ? dw_x : $signed({{(CW-DW){1'b0}}, cfg.sw});
    sh_x     = cmd.opcode ? dh_x : $signed({{(CW-DW){1'b0}}, cfg.sh});

    a_nxt.cl       = max3('0, -left_x, -fx_x);
    a_nxt.cr       = min3(right_x - left_x, dw_x - left_x, sw_x - fx_x);
    a_nxt.ct       = max3('0, -top_x, -fy_x);
    a_nxt.cb       = min3(bottom_x - top_x, dh_x - top_x, sh_x - fy_x);
    a_nxt.left     = cmd.rect_left;
    a_nxt.top      = cmd.rect_top;
    a_nxt.fx       = cmd.from_x;
    a_nxt.fy       = cmd.from_y;
    a_nxt.move     = cmd.opcode;
    a_nxt.up       = cmd.opcode && !(cmd.from_y > cmd.rect_top);
    a_nxt.mismatch = !cmd.opcode && !cfg.formats_match;
  end

  // Stage B: empty test and first-row coordinates
  always_comb begin
    empty    = (a_r.cr <= a_r.cl) || (a_r.cb <= a_r.ct) || (cfg.bpp == '0);
    row_base = a_r.up ? (a_r.cb - $signed(CW'(1))) : a_r.ct;
    dcol_x   = CW'(a_r.left) + a_r.cl;
    scol_x   = CW'(a_r.fx) + a_r.cl;
    drow_x   = CW'(a_r.top) + row_base;
    srow_x   = CW'(a_r.fy) + row_base;
    cols_x   = a_r.cr - a_r.cl;
    rows_x   = a_r.cb - a_r.ct;

    b_nxt = '0;
    if (a_r.mismatch) begin
      b_nxt.status = brc_pkg::STATUS_MISMATCH;
    end else if (empty) begin
      b_nxt.status = brc_pkg::STATUS_EMPTY;
    end else begin
      b_nxt.status = brc_pkg::STATUS_OK;
      b_nxt.move   = a_r.move;
      b_nxt.up     = a_r.up;
      b_nxt.dcol   = dcol_x[DW-1:0];
      b_nxt.scol   = scol_x[DW-1:0];
      b_nxt.drow   = drow_x[DW-1:0];
      b_nxt.srow   = srow_x[DW-1:0];
      b_nxt.rows   = rows_x[DW-1:0];
      b_nxt.cols   = cols_x[DW-1:0];
    end
  end

  // Per-stage flow control: a stage loads when empty or when it drains
  assign a_ready   = !a_valid_r || b_ready;
  assign b_ready   = !b_valid_r || span_ready;
  assign cmd.ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= cmd.valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && cmd.valid) begin
      a_r <= a_nxt;
    end
    if (b_ready && a_valid_r) begin
      b_r <= b_nxt;
    end
  end

  assign span_valid = b_valid_r;
  assign span       = b_r;

endmodule

`default_nettype wire

>>> design/brc_addr.sv
// ----------------------------------------------------------------------------
// brc_addr
// Two pipeline stages: row times stride plus column, then scaling by the
// pixel size into byte offsets. The last stage is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brc_addr (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            span_valid,
  output logic                 span_ready,
  input  wire brc_pkg::span_t  span,
  input  wire brc_pkg::cfg_t   cfg,
  brc_desc_if.source           desc
);

  localparam int DW = brc_pkg::DIM_W;
  localparam int OW = brc_pkg::OFS_W;
  localparam int BW = brc_pkg::BPP_W;
  localparam int RW = brc_pkg::ROWB_W;

  typedef struct packed {
    brc_pkg::status_t status;
    logic             up;
    logic [OW-1:0]    dlin;
    logic [OW-1:0]    slin;
    logic [DW-1:0]    rows;
    logic [RW-1:0]    row_bytes;
  } lin_t;

  typedef struct packed {
    brc_pkg::status_t status;
    logic             up;
    logic [OW-1:0]    dofs;
    logic [OW-1:0]    sofs;
    logic [DW-1:0]    rows;
    logic [RW-1:0]    row_bytes;
  } ofs_t;

  logic              c_valid_r, d_valid_r;
  logic              c_ready, d_ready;
  lin_t              c_r, c_nxt;
  ofs_t              d_r, d_nxt;

  logic [DW-1:0]     stride;
  logic [2*DW-1:0]   dprod, sprod;
  logic [DW+BW-1:0]  rb_full;
  logic [OW+BW-1:0]  dfull, sfull;

  // Stage C: linear pixel index of the first row start
  always_comb begin
    stride  = span.move ? cfg.dw : cfg.sw;
    dprod   = (2*DW)'(span.drow) * (2*DW)'(cfg.dw);
    sprod   = (2*DW)'(span.srow) * (2*DW)'(stride);
    rb_full = (DW+BW)'(span.cols) * (DW+BW)'(cfg.bpp);

    c_nxt.status    = span.status;
    c_nxt.up        = span.up;
    c_nxt.dlin      = OW'(dprod) + OW'(span.dcol);
    c_nxt.slin      = OW'(sprod) + OW'(span.scol);
    c_nxt.rows      = span.rows;
    c_nxt.row_bytes = rb_full[RW-1:0];
  end

  // Stage D: scale to bytes, wrap at the offset width
  always_comb begin
    dfull = (OW+BW)'(c_r.dlin) * (OW+BW)'(cfg.bpp);
    sfull = (OW+BW)'(c_r.slin) * (OW+BW)'(cfg.bpp);

    d_nxt.status    = c_r.status;
    d_nxt.up        = c_r.up;
    d_nxt.dofs      = dfull[OW-1:0];
    d_nxt.sofs      = sfull[OW-1:0];
    d_nxt.rows      = c_r.rows;
    d_nxt.row_bytes = c_r.row_bytes;
  end

  assign c_ready    = !c_valid_r || d_ready;
  assign d_ready    = !d_valid_r || desc.ready;
  assign span_ready = c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_r <= span_valid;
      end
      if (d_ready) begin
        d_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && span_valid) begin
      c_r <= c_nxt;
    end
    if (d_ready && c_valid_r) begin
      d_r <= d_nxt;
    end
  end

  // Output register drives the descriptor channel
  assign desc.valid         = d_valid_r;
  assign desc.status        = d_r.status;
  assign desc.dest_offset   = d_r.dofs;
  assign desc.source_offset = d_r.sofs;
  assign desc.row_count     = d_r.rows;
  assign desc.row_bytes     = d_r.row_bytes;
  assign desc.bottom_up     = d_r.up;

endmodule

`default_nettype wire

>>> design/blit_rect_clip_address_gen.sv
// ----------------------------------------------------------------------------
// blit_rect_clip_address_gen
// Clips one blit command per transaction against the source and destination
// buffers and returns one row-transfer descriptor per command.
//
// Channels: in_cmd carries the command (opcode, destination rectangle,
// source corner); out_desc carries status, byte offsets of the first row,
// row count, bytes per row and the bottom-up flag. cfg_we/cfg_index/cfg_data
// write the buffer sizes, pixel size and format-match flag; change them only
// while no command is in flight.
// Throughput: one command per clock when out_desc does not stall. Pipeline:
// four register stages (clip, span, stride multiply, pixel-size multiply),
// which a command passes through in that order on its way to out_desc.
// Stall: a full stage holds while the next stage is full and stalled, so
// bubbles close up; in_cmd.ready drops only when all four stages are full.
// Reset: pipeline emptied, dimensions cleared to zero, pixel size to 4 bytes,
// formats marked matching.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "blit_rect_clip_address_gen_macros.svh"

module blit_rect_clip_address_gen #(
  parameter int MAX_DIM             = brc_pkg::MAX_DIM_DEF,
  parameter int MAX_BYTES_PER_PIXEL = brc_pkg::MAX_BPP_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  brc_cmd_if.sink                              in_cmd,
  brc_desc_if.source                           out_desc,
  input  wire logic                            cfg_we,
  input  wire logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [brc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DW        = brc_pkg::DIM_W;
  localparam int BW        = brc_pkg::BPP_W;
  localparam int DIM_CAP_W = DW + 2;
  localparam int BPP_CAP_W = BW + 1;
  localparam logic [DIM_CAP_W-1:0] DIM_CAP = DIM_CAP_W'(MAX_DIM);
  localparam logic [BPP_CAP_W-1:0] BPP_CAP = BPP_CAP_W'(MAX_BYTES_PER_PIXEL);

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    return (DIM_CAP_W'(v) > DIM_CAP) ? DIM_CAP[DW-1:0] : v;
  endfunction

  logic [DW-1:0]   dest_width_r, dest_height_r, source_width_r, source_height_r;
  logic [BW-1:0]   bytes_per_pixel_r;
  logic            formats_match_r;
  brc_pkg::cfg_t   cfg;

  logic            span_valid, span_ready;
  brc_pkg::span_t  span;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_width_r      <= '0;
      dest_height_r     <= '0;
      source_width_r    <= '0;
      source_height_r   <= '0;
      bytes_per_pixel_r <= brc_pkg::BPP_RESET;
      formats_match_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        brc_pkg::CFG_DEST_WIDTH:      dest_width_r      <= cfg_data[DW-1:0];
        brc_pkg::CFG_DEST_HEIGHT:     dest_height_r     <= cfg_data[DW-1:0];
        brc_pkg::CFG_SOURCE_WIDTH:    source_width_r    <= cfg_data[DW-1:0];
        brc_pkg::CFG_SOURCE_HEIGHT:   source_height_r   <= cfg_data[DW-1:0];
        brc_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel_r <= cfg_data[BW-1:0];
        brc_pkg::CFG_FORMATS_MATCH:   formats_match_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate oversized settings
  always_comb begin
    cfg.dw            = clamp_dim(dest_width_r);
    cfg.dh            = clamp_dim(dest_height_r);
    cfg.sw            = clamp_dim(source_width_r);
    cfg.sh            = clamp_dim(source_height_r);
    cfg.bpp           = (BPP_CAP_W'(bytes_per_pixel_r) > BPP_CAP) ? BPP_CAP[BW-1:0]
                                                                  : bytes_per_pixel_r;
    cfg.formats_match = formats_match_r;
  end

  brc_clip u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (in_cmd),
    .cfg        (cfg),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span)
  );

  brc_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span),
    .cfg        (cfg),
    .desc       (out_desc)
  );

  // Checks
  `BRC_ASSERT_IMPL(a_fields_zero_unless_ok, clk, rst_n,
    out_desc.valid && out_desc.status != brc_pkg::STATUS_OK,
    out_desc.dest_offset == '0 && out_desc.source_offset == '0 &&
      out_desc.row_count == '0 && out_desc.row_bytes == '0 && !out_desc.bottom_up,
    "descriptor fields not cleared for a non-ok status")
  `BRC_ASSERT_IMPL(a_ok_has_area, clk, rst_n,
    out_desc.valid && out_desc.status == brc_pkg::STATUS_OK,
    out_desc.row_count != '0 && out_desc.row_bytes != '0,
    "ok descriptor with no rows or no bytes")
  `BRC_ASSERT_IMPL(a_stall_means_full, clk, rst_n,
    !in_cmd.ready, out_desc.valid,
    "command side stalled with an empty output register")
  `BRC_ASSERT_NEXT(a_latency, clk, rst_n,
    (in_cmd.valid && in_cmd.ready) ##1 out_desc.ready ##1 out_desc.ready ##1 out_desc.ready,
    out_desc.valid,
    "accepted command did not reach the output in four stages")

endmodule

`default_nettype wire
